>>> src/png_scanline_unfilter_assert.svh
// Assertion macros shared by the PNG scanline unfilter RTL.
// No dependencies; included by the top level only.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSU_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PSU_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/pngsu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// No dependencies; imported by the top level.
package pngsu_pkg;

    // Register indexes of the configuration port
    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_BPP       = 1'b1;

    localparam int unsigned ROW_WIDTH_W = 13;
    localparam int unsigned BPP_CFG_W   = 3;
    localparam logic [7:0]  FILT_MAX    = 8'd4;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

endpackage

>>> src/pngsu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pngsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/png_scanline_unfilter.sv
// PNG scanline unfilter (None/Sub/Up/Average/Paeth), one byte per cycle unless m_ready stalls.
// Uses pngsu_pkg, pngsu_ram and png_scanline_unfilter_assert.svh.
//
// Usage:
//   Input channel s_*: one inflated byte per request. The first byte of a row
//   is its filter type; s_image_start marks the first byte of an image.
//   Output channel m_*: one reconstructed byte per sample request, with
//   m_row_end on the row's last byte. A filter type above 4 produces one
//   result with m_bad_filter set and the row then passes through unchanged.
//   Filter-type bytes otherwise produce no result.
//   Configuration (cfg_we/cfg_index/cfg_data) is written between requests
//   while the block is idle; row width and bytes per pixel apply at once.
// Timing:
//   m_valid comes from the output register, fed by the stage-1 register that
//   takes the accepted byte. Throughput is one byte per cycle unless stalled;
//   the row store is read in the accept cycle and written back from stage 1,
//   and the left-neighbor registers close the Sub/Average/Paeth loop.
//   When m_ready is low with a result pending, the whole pipe holds and
//   s_ready drops; otherwise a new byte is taken while a result is waiting.
// Reset:
//   aresetn (synchronous, active low) clears control state and returns the
//   block to expecting a filter byte on a first row. The row store is not
//   cleared; the first row of every image ignores what it reads from it.
module png_scanline_unfilter
    import pngsu_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [ROW_WIDTH_W-1:0] cfg_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_image_start,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_pixel_byte,
    output logic                   m_row_end,
    output logic                   m_bad_filter
);

    `include "png_scanline_unfilter_assert.svh"

    localparam int POS_W  = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PROD_W = ROW_WIDTH_W + BPP_W;

    // Stage-1 request record
    typedef struct packed {
        logic              valid;
        logic              is_filter;
        logic              start;
        logic              bad;
        logic [7:0]        data;
        logic [SLOT_W-1:0] slot;
        logic              has_left;
        logic              last;
        logic              first_row;
        filter_t           filter;
        logic [POS_W-1:0]  pos;
    } stage_t;

    // Paeth predictor on 8-bit neighbors
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    // ---------------- configuration registers ----------------
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [BPP_CFG_W-1:0]   bpp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_W'(1);
            bpp_reg       <= BPP_CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_WIDTH: row_width_reg <= cfg_data;
                CFG_BPP:       bpp_reg       <= cfg_data[BPP_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective bytes per pixel and row length in bytes
    logic [BPP_CFG_W:0]     bpp_ext;
    logic [BPP_W-1:0]       eff_bpp;
    logic [ROW_WIDTH_W-1:0] eff_width;
    logic [PROD_W-1:0]      row_prod;
    logic [ROW_W-1:0]       row_bytes;

    always_comb begin
        bpp_ext = {1'b0, bpp_reg};
        if (bpp_ext == '0) begin
            eff_bpp = BPP_W'(1);
        end else if (bpp_ext > (BPP_CFG_W+1)'(MAX_PIXEL_BYTES)) begin
            eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            eff_bpp = BPP_W'(bpp_ext);
        end
        eff_width = (row_width_reg == '0) ? ROW_WIDTH_W'(1) : row_width_reg;
        row_prod  = PROD_W'(eff_width) * PROD_W'(eff_bpp);
        row_bytes = (row_prod > PROD_W'(MAX_ROW_BYTES)) ? ROW_W'(MAX_ROW_BYTES)
                                                       : ROW_W'(row_prod);
    end

    // ---------------- stage 0: row position tracking ----------------
    logic              pipe_en;
    logic              s_accept;
    logic              expect_filter_reg, expect_filter_next;
    logic              first_row_reg, first_row_next;
    filter_t           filter_reg, filter_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    // pos modulo each possible pixel size, one counter per size
    logic [SLOT_W-1:0] mod_reg [MAX_PIXEL_BYTES];
    logic [SLOT_W-1:0] mod_next [MAX_PIXEL_BYTES];
    logic              in_filter;
    logic              in_first;
    logic [SLOT_W-1:0] slot_sel;
    logic              has_left;
    logic              is_last;
    logic              pos_clear;
    logic              pos_inc;
    stage_t            st1_reg, st1_next;

    assign pipe_en  = !m_valid || m_ready;
    assign s_ready  = pipe_en;
    assign s_accept = s_valid && pipe_en;

    always_comb begin
        in_filter = s_image_start || expect_filter_reg;
        in_first  = s_image_start || first_row_reg;
        slot_sel  = mod_reg[SLOT_W'(eff_bpp - BPP_W'(1))];
        has_left  = pos_reg >= POS_W'(eff_bpp);
        is_last   = (ROW_W'(pos_reg) + ROW_W'(1)) >= row_bytes;

        expect_filter_next = expect_filter_reg;
        first_row_next     = first_row_reg;
        filter_next        = filter_reg;
        pos_clear          = 1'b0;
        pos_inc            = 1'b0;

        if (s_accept) begin
            if (in_filter) begin
                expect_filter_next = 1'b0;
                first_row_next     = in_first;
                filter_next        = (s_data_byte > FILT_MAX) ? FILT_NONE
                                                              : filter_t'(s_data_byte[2:0]);
                pos_clear          = 1'b1;
            end else if (is_last) begin
                expect_filter_next = 1'b1;
                first_row_next     = 1'b0;
                pos_clear          = 1'b1;
            end else begin
                pos_inc = 1'b1;
            end
        end

        pos_next = pos_clear ? '0 : (pos_inc ? pos_reg + POS_W'(1) : pos_reg);
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            if (pos_clear) begin
                mod_next[i] = '0;
            end else if (pos_inc) begin
                mod_next[i] = (mod_reg[i] == SLOT_W'(i)) ? '0 : mod_reg[i] + SLOT_W'(1);
            end else begin
                mod_next[i] = mod_reg[i];
            end
        end

        st1_next.valid     = s_valid;
        st1_next.is_filter = in_filter;
        st1_next.start     = s_image_start;
        st1_next.bad       = s_data_byte > FILT_MAX;
        st1_next.data      = s_data_byte;
        st1_next.slot      = slot_sel;
        st1_next.has_left  = has_left;
        st1_next.last      = is_last;
        st1_next.first_row = first_row_reg;
        st1_next.filter    = filter_reg;
        st1_next.pos       = pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_filter_reg <= 1'b1;
            first_row_reg     <= 1'b1;
            filter_reg        <= FILT_NONE;
            pos_reg           <= '0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                mod_reg[i] <= '0;
            end
            st1_reg.valid     <= 1'b0;
        end else begin
            expect_filter_reg <= expect_filter_next;
            first_row_reg     <= first_row_next;
            filter_reg        <= filter_next;
            pos_reg           <= pos_next;
            mod_reg           <= mod_next;
            if (pipe_en) begin
                st1_reg <= st1_next;
            end
        end
    end

    // ---------------- row store ----------------
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;
    logic [7:0] recon;

    assign ram_re = s_accept && !in_filter;
    assign ram_we = pipe_en && st1_reg.valid && !st1_reg.is_filter;

    pngsu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (st1_reg.pos),
        .wdata (recon),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1: reconstruction ----------------
    logic [7:0] recent_bytes_reg [MAX_PIXEL_BYTES];
    logic [7:0] recent_above_reg [MAX_PIXEL_BYTES];
    logic [7:0] nb_left;
    logic [7:0] nb_up;
    logic [7:0] nb_diag;
    logic [8:0] avg_sum;
    logic [7:0] pred;

    always_comb begin
        nb_up   = st1_reg.first_row ? 8'd0 : ram_rdata;
        nb_left = st1_reg.has_left ? recent_bytes_reg[st1_reg.slot] : 8'd0;
        nb_diag = (st1_reg.has_left && !st1_reg.first_row) ? recent_above_reg[st1_reg.slot]
                                                           : 8'd0;
        avg_sum = {1'b0, nb_left} + {1'b0, nb_up};
        case (st1_reg.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = nb_left;
            FILT_UP:    pred = nb_up;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(nb_left, nb_up, nb_diag);
            default:    pred = 8'd0;
        endcase
        recon = st1_reg.data + pred;
    end

    // Left-neighbor registers; an image start clears them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                recent_bytes_reg[i] <= '0;
                recent_above_reg[i] <= '0;
            end
        end else if (pipe_en && st1_reg.valid) begin
            if (st1_reg.is_filter) begin
                if (st1_reg.start) begin
                    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                        recent_bytes_reg[i] <= '0;
                        recent_above_reg[i] <= '0;
                    end
                end
            end else begin
                recent_bytes_reg[st1_reg.slot] <= recon;
                recent_above_reg[st1_reg.slot] <= nb_up;
            end
        end
    end

    // ---------------- output register ----------------
    logic       m_valid_reg;
    logic [7:0] m_pixel_reg;
    logic       m_row_end_reg;
    logic       m_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= st1_reg.valid && (!st1_reg.is_filter || st1_reg.bad);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_pixel_reg   <= st1_reg.is_filter ? 8'd0 : recon;
            m_row_end_reg <= !st1_reg.is_filter && st1_reg.last;
            m_bad_reg     <= st1_reg.is_filter;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_byte = m_pixel_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_bad_filter = m_bad_reg;

    // ---------------- assertions ----------------
    `PSU_ASSERT_NOW(a_bad_result_clean, aclk, aresetn, m_valid && m_bad_filter, m_pixel_byte == 8'd0 && !m_row_end, "bad filter result carries data")
    `PSU_ASSERT_NOW(a_no_ram_collision, aclk, aresetn, ram_we && ram_re, st1_reg.pos != pos_reg, "row store read and write hit the same entry")
    `PSU_ASSERT_NEXT(a_row_end_expects_filter, aclk, aresetn, s_accept && !in_filter && is_last, expect_filter_reg && pos_reg == '0, "row end did not return to filter byte")

endmodule
